/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file apg_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under reset
`define APG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication under reset
`define APG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/apg_pkg.sv */
// Shared constants, types and the arctangent table for the arc generator
`timescale 1ns / 1ps
`default_nettype none
package apg_pkg;
	localparam int MAX_POINTS_DEF   = 64;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int CW   = 50;  // CORDIC x/y datapath width
	localparam int ZW   = 33;  // CORDIC angle accumulator width
	localparam int DVW  = 22;  // divider dividend width
	localparam int SGW  = 7;   // segment count width
	localparam logic [31:0] GAIN_Q32 = 32'd2608131496;

	localparam logic [1:0] OP_ARC_ANGLES = 2'd0;
	localparam logic [1:0] OP_ARC_POINTS = 2'd1;
	localparam logic [1:0] OP_CIRCLE     = 2'd2;

	typedef struct packed {
		logic start;
		logic vec;  // 1: vectoring (atan2), 0: rotation
	} cordic_req_t;

	function automatic logic [31:0] atan_turn(input logic [4:0] idx);
		logic [31:0] v;
		case (idx)
			5'd0:  v = 32'h20000000;
			5'd1:  v = 32'h12E4051E;
			5'd2:  v = 32'h09FB385B;
			5'd3:  v = 32'h051111D4;
			5'd4:  v = 32'h028B0D43;
			5'd5:  v = 32'h0145D7E1;
			5'd6:  v = 32'h00A2F61E;
			5'd7:  v = 32'h00517C55;
			5'd8:  v = 32'h0028BE53;
			5'd9:  v = 32'h00145F2F;
			5'd10: v = 32'h000A2F98;
			5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6;
			5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2FA;
			5'd15: v = 32'h0000517D;
			5'd16: v = 32'h000028BE;
			5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A30;
			5'd19: v = 32'h00000518;
			5'd20: v = 32'h0000028C;
			5'd21: v = 32'h00000146;
			5'd22: v = 32'h000000A3;
			5'd23: v = 32'h00000051;
			default: v = 32'h0;
		endcase
		return v;
	endfunction
endpackage
`default_nettype wire

/* hw/rtl/apg_cordic.sv */
// Iterative CORDIC, one micro-rotation per cycle, vectoring or rotation mode
`timescale 1ns / 1ps
`default_nettype none
module apg_cordic #(
	parameter int CORDIC_STEPS = 16
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire  apg_pkg::cordic_req_t       req,
	input  wire  logic signed [apg_pkg::CW-1:0] x_in,
	input  wire  logic signed [apg_pkg::CW-1:0] y_in,
	input  wire  logic signed [apg_pkg::ZW-1:0] z_in,
	output logic                             done,
	output logic signed [apg_pkg::CW-1:0]    x_out,
	output logic signed [apg_pkg::ZW-1:0]    z_out,
	output logic signed [apg_pkg::CW-1:0]    y_out
);
	import apg_pkg::*;
	localparam int NW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

	logic signed [CW-1:0] x_q, y_q, xs, ys;
	logic signed [ZW-1:0] z_q, at;
	logic [NW-1:0] cnt_q;
	logic run_q, vec_q, done_q, up;

	assign xs = x_q >>> cnt_q;
	assign ys = y_q >>> cnt_q;
	assign at = $signed({1'b0, atan_turn(5'(cnt_q))});
	assign up = vec_q ? !y_q[CW-1] : z_q[ZW-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			vec_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				vec_q <= req.vec;
				cnt_q <= '0;
				x_q   <= x_in;
				y_q   <= y_in;
				z_q   <= z_in;
			end else if (run_q) begin
				x_q <= up ? x_q + ys : x_q - ys;
				y_q <= up ? y_q - xs : y_q + xs;
				z_q <= up ? z_q + at : z_q - at;
				if (cnt_q == NW'(CORDIC_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	assign done  = done_q;
	assign x_out = x_q;
	assign y_out = y_q;
	assign z_out = z_q;
endmodule
`default_nettype wire

/* hw/rtl/apg_divider.sv */
// Restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module apg_divider (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        start,
	input  wire  [apg_pkg::DVW-1:0]    dividend,
	input  wire  [apg_pkg::SGW-1:0]    divisor,
	output logic                       done,
	output logic [apg_pkg::DVW-1:0]    quotient
);
	import apg_pkg::*;
	localparam int KW = $clog2(DVW);

	logic [DVW-1:0] quo_q;
	logic [SGW:0]   rem_q, trial;
	logic [SGW-1:0] div_q;
	logic [KW-1:0]  cnt_q;
	logic run_q, done_q, ge;

	assign trial = {rem_q[SGW-1:0], quo_q[DVW-1]};
	assign ge    = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
				quo_q <= dividend;
				rem_q <= '0;
				div_q <= divisor;
			end else if (run_q) begin
				rem_q <= ge ? trial - {1'b0, div_q} : trial;
				quo_q <= {quo_q[DVW-2:0], ge};
				if (cnt_q == KW'(DVW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule
`default_nettype wire

/* hw/rtl/arc_polyline_generator_unit.sv */
// Arc and circle polyline generator: sequencer around a shared CORDIC and divider
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | opcode, centre, radius, angles, points, segments
//   vtx     | out       | vtx_valid/vtx_stall | vertex_x, vertex_y, last
// Per request a gain step; arcs add a span step, opcode 1 up to two CORDIC vectoring runs.
// Per vertex: a divider run, a CORDIC rotation and an output state.
// req_stall is high after acceptance until the last vertex is taken (for opcode 3, until
// the gain state ends); vtx_stall holds the sequencer while a vertex is shown. Reset
// clears the sequencer, vtx_valid and the CORDIC and divider start strobes.
`timescale 1ns / 1ps
`default_nettype none
module arc_polyline_generator_unit #(
	parameter int MAX_POINTS   = apg_pkg::MAX_POINTS_DEF,
	parameter int CORDIC_STEPS = apg_pkg::CORDIC_STEPS_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 req_valid,
	output logic                req_stall,
	input  wire  [1:0]          opcode,
	input  wire  signed [31:0]  center_x,
	input  wire  signed [31:0]  center_y,
	input  wire  [30:0]         radius,
	input  wire  [15:0]         start_angle,
	input  wire  [15:0]         end_angle,
	input  wire  signed [31:0]  first_x,
	input  wire  signed [31:0]  first_y,
	input  wire  signed [31:0]  second_x,
	input  wire  signed [31:0]  second_y,
	input  wire  [6:0]          segments,
	output logic                vtx_valid,
	input  wire                 vtx_stall,
	output logic signed [31:0]  vertex_x,
	output logic signed [31:0]  vertex_y,
	output logic                last
);
	import apg_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_GAIN, ST_VEC, ST_VWAIT, ST_SPAN, ST_DIV, ST_DWAIT, ST_ROT,
		ST_RWAIT, ST_OUT
	} state_t;

	state_t state_q;
	logic [1:0] op_q;
	logic signed [31:0] cx_q, cy_q, p0x_q, p0y_q, p1x_q, p1y_q;
	logic [30:0] r_q;
	logic [15:0] a0_q, a1_q, ang_q;
	logic signed [15:0] span_q;
	logic [SGW-1:0] seg_q, lim_q, i_q;
	logic [46:0] x0_q;
	logic pidx_q, arc_q;
	cordic_req_t creq_q;
	logic signed [CW-1:0] cx_in_q, cy_in_q;
	logic signed [ZW-1:0] cz_in_q;
	logic dstart_q;
	logic [DVW-1:0] dvd_q;
	logic out_v_q, last_q;
	logic signed [31:0] vx_q, vy_q;

	// combinational helpers
	logic [SGW-1:0] seg_in;
	logic signed [32:0] dx, dy;
	logic c_done, d_done;
	logic signed [CW-1:0] c_x, c_y;
	logic signed [ZW-1:0] c_z;
	logic [DVW-1:0] quo;
	logic [15:0] span_abs, q16;
	logic [22:0] prod;
	logic [62:0] gprod;
	logic [ZW-1:0] vround;
	logic signed [CW-1:0] xr_full, yr_full;
	logic signed [34:0] xr, yr;
	logic signed [35:0] sx, sy;
	logic [15:0] t_ang;

	assign seg_in = (segments == '0) ? SGW'(1) : segments;
	assign dx = pidx_q ? (33'(p1x_q) - 33'(cx_q)) : (33'(p0x_q) - 33'(cx_q));
	assign dy = pidx_q ? (33'(p1y_q) - 33'(cy_q)) : (33'(p0y_q) - 33'(cy_q));
	assign span_abs = span_q[15] ? 16'(-span_q) : 16'(span_q);
	assign prod = 23'(span_abs) * 23'(i_q);
	assign gprod = 63'(r_q) * 63'(GAIN_Q32);
	assign q16 = span_q[15] ? 16'(-quo[15:0]) : quo[15:0];
	assign vround = c_z + ZW'(32'h8000);
	assign t_ang = ang_q;
	assign xr_full = (c_x + $signed(CW'(32'h8000))) >>> 16;
	assign yr_full = (c_y + $signed(CW'(32'h8000))) >>> 16;
	assign xr = (t_ang[15] ^ t_ang[14]) ? -35'(xr_full) : 35'(xr_full);
	assign yr = (t_ang[15] ^ t_ang[14]) ? -35'(yr_full) : 35'(yr_full);
	assign sx = 36'(cx_q) + 36'(xr);
	assign sy = 36'(cy_q) + 36'(yr);

	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		logic signed [31:0] r;
		if (v > 36'sd2147483647)
			r = 32'sh7FFFFFFF;
		else if (v < -36'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			creq_q   <= '0;
			dstart_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			creq_q.start <= 1'b0;
			dstart_q     <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						op_q  <= opcode;
						cx_q  <= center_x;
						cy_q  <= center_y;
						r_q   <= radius;
						a0_q  <= start_angle;
						a1_q  <= end_angle;
						p0x_q <= first_x;
						p0y_q <= first_y;
						p1x_q <= second_x;
						p1y_q <= second_y;
						arc_q <= opcode != OP_CIRCLE;
						if (opcode == OP_CIRCLE) begin
							seg_q <= (seg_in > SGW'(MAX_POINTS)) ? SGW'(MAX_POINTS) : seg_in;
							lim_q <= ((seg_in > SGW'(MAX_POINTS)) ? SGW'(MAX_POINTS)
								: seg_in) - 1'b1;
						end else begin
							seg_q <= (seg_in > SGW'(MAX_POINTS - 1)) ? SGW'(MAX_POINTS - 1)
								: seg_in;
							lim_q <= (seg_in > SGW'(MAX_POINTS - 1)) ? SGW'(MAX_POINTS - 1)
								: seg_in;
						end
						i_q    <= '0;
						pidx_q <= 1'b0;
						state_q <= ST_GAIN;
					end
				end
				ST_GAIN: begin
					x0_q <= gprod[62:16];
					case (op_q)
						OP_ARC_ANGLES: state_q <= ST_SPAN;
						OP_ARC_POINTS: state_q <= ST_VEC;
						OP_CIRCLE:     state_q <= ST_DIV;
						default:       state_q <= ST_IDLE;
					endcase
				end
				ST_VEC: begin
					if (dx == '0 && dy == '0) begin
						// point on the centre: angle 0
						if (pidx_q) begin
							a1_q <= '0;
							state_q <= ST_SPAN;
						end else begin
							a0_q <= '0;
							pidx_q <= 1'b1;
						end
					end else begin
						creq_q  <= '{start: 1'b1, vec: 1'b1};
						cx_in_q <= dx[32] ? -CW'(dx) : CW'(dx);
						cy_in_q <= dx[32] ? -CW'(dy) : CW'(dy);
						cz_in_q <= dx[32] ? ZW'(32'h80000000) : '0;
						state_q <= ST_VWAIT;
					end
				end
				ST_VWAIT: begin
					if (c_done) begin
						if (pidx_q) begin
							a1_q <= vround[31:16];
							state_q <= ST_SPAN;
						end else begin
							a0_q <= vround[31:16];
							pidx_q <= 1'b1;
							state_q <= ST_VEC;
						end
					end
				end
				ST_SPAN: begin
					span_q  <= $signed(a1_q - a0_q);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					dvd_q    <= arc_q ? DVW'(prod) : {i_q[5:0], 16'h0};
					dstart_q <= 1'b1;
					state_q  <= ST_DWAIT;
				end
				ST_DWAIT: begin
					if (d_done) begin
						ang_q   <= arc_q ? a0_q + q16 : quo[15:0];
						state_q <= ST_ROT;
					end
				end
				ST_ROT: begin
					creq_q  <= '{start: 1'b1, vec: 1'b0};
					cx_in_q <= CW'(x0_q);
					cy_in_q <= '0;
					// fold the left half plane onto the right, undone on the result
					cz_in_q <= ZW'($signed({ang_q[14], ang_q[14:0], 16'h0}));
					state_q <= ST_RWAIT;
				end
				ST_RWAIT: begin
					if (c_done) begin
						vx_q    <= sat32(sx);
						vy_q    <= sat32(sy);
						last_q  <= i_q == lim_q;
						out_v_q <= 1'b1;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!vtx_stall) begin
						out_v_q <= 1'b0;
						i_q     <= i_q + 1'b1;
						state_q <= last_q ? ST_IDLE : ST_DIV;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	apg_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .req(creq_q),
		.x_in(cx_in_q), .y_in(cy_in_q), .z_in(cz_in_q),
		.done(c_done), .x_out(c_x), .z_out(c_z), .y_out(c_y)
	);

	apg_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart_q),
		.dividend(dvd_q), .divisor(seg_q),
		.done(d_done), .quotient(quo)
	);

	assign req_stall = state_q != ST_IDLE;
	assign vtx_valid = out_v_q;
	assign vertex_x  = vx_q;
	assign vertex_y  = vy_q;
	assign last      = last_q;
endmodule
`default_nettype wire

/* hw/rtl/apg_checker.sv */
// Port-level assertions for the arc generator, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module apg_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        req_valid,
	input wire        req_stall,
	input wire        vtx_valid,
	input wire        vtx_stall,
	input wire [31:0] vertex_x,
	input wire        last
);
	// a shown vertex blocks new requests
	`APG_ASSERT_NOW(a_busy_out, clk, arst_n, vtx_valid, req_stall, "vertex shown while idle")
	// an accepted request is followed by a busy block (req_stall high)
	`APG_ASSERT_NEXT(a_take_busy, clk, arst_n, req_valid && !req_stall, req_stall,
		"not busy after request")
	// the final vertex, once taken, drops vtx_valid and frees the input side
	`APG_ASSERT_NEXT(a_last_free, clk, arst_n, vtx_valid && !vtx_stall && last, !vtx_valid,
		"vertex after final")
	// stalled vertex holds valid, vertex_x and last
	`APG_ASSERT_NEXT(a_hold, clk, arst_n, vtx_valid && vtx_stall,
		vtx_valid && $stable(vertex_x) && $stable(last), "stalled vertex changed")
endmodule

bind arc_polyline_generator_unit apg_checker u_apg_checker (
	.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_stall(req_stall),
	.vtx_valid(vtx_valid), .vtx_stall(vtx_stall), .vertex_x(vertex_x), .last(last)
);
`default_nettype wire

/* verif/tb_top.sv */
// Self-checking testbench for the arc and circle polyline generator
`timescale 1ns / 1ps
module tb_top;
	import apg_pkg::*;

	localparam int MAXP  = 64;
	localparam int STEPS = 16;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic               lst;
	} vertex_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic [1:0] opcode = '0;
	logic signed [31:0] center_x = '0, center_y = '0;
	logic [30:0] radius = '0;
	logic [15:0] start_angle = '0, end_angle = '0;
	logic signed [31:0] first_x = '0, first_y = '0, second_x = '0, second_y = '0;
	logic [6:0] segments = '0;
	logic vtx_valid;
	logic vtx_stall = 1'b0;
	logic signed [31:0] vertex_x, vertex_y;
	logic last;

	vertex_t expected_vertices[$];
	int errors = 0;
	int requests_sent = 0;
	int vertices_seen = 0;
	int op_count[4];
	bit stall_enable = 1'b1;

	arc_polyline_generator_unit dut (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_stall(req_stall),
		.opcode(opcode), .center_x(center_x), .center_y(center_y), .radius(radius),
		.start_angle(start_angle), .end_angle(end_angle), .first_x(first_x),
		.first_y(first_y), .second_x(second_x), .second_y(second_y),
		.segments(segments), .vtx_valid(vtx_valid), .vtx_stall(vtx_stall),
		.vertex_x(vertex_x), .vertex_y(vertex_y), .last(last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#400ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic logic [31:0] atan_step(int i);
		logic [31:0] t[24] = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
			32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53,
			32'h00145F2F, 32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3,
			32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30,
			32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
		return t[i];
	endfunction

	// >>> on signed longint is a floor shift
	function automatic logic [15:0] direction_angle(longint dx, longint dy);
		longint x, y, acc, xs, ys;
		logic [63:0] u;
		if (dx == 0 && dy == 0) return 16'd0;
		x = dx; y = dy; acc = 0;
		if (x < 0) begin
			x = -x; y = -y; acc = 64'sh80000000;
		end
		for (int i = 0; i < STEPS; i++) begin
			xs = x >>> i; ys = y >>> i;
			if (y >= 0) begin
				x += ys; y -= xs; acc += longint'(atan_step(i));
			end else begin
				x -= ys; y += xs; acc -= longint'(atan_step(i));
			end
		end
		u = acc + 64'sh8000;
		return u[31:16];
	endfunction

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic vertex_t point_on_circle(longint cx, longint cy, logic [30:0] r,
			logic [15:0] ang, bit lst);
		logic [31:0] t;
		bit flip;
		longint x, y, z, xs, ys;
		logic [63:0] prod;
		vertex_t v;
		t = {ang, 16'h0};
		flip = (t >= 32'h40000000 && t < 32'hC0000000);
		if (flip) t = t - 32'h80000000;
		z = longint'(signed'(t));
		prod = 64'(r) * 64'(GAIN_Q32);
		x = longint'(prod >> 16);
		y = 0;
		for (int i = 0; i < STEPS; i++) begin
			xs = x >>> i; ys = y >>> i;
			if (z >= 0) begin
				x -= ys; y += xs; z -= longint'(atan_step(i));
			end else begin
				x += ys; y -= xs; z += longint'(atan_step(i));
			end
		end
		x = (x + 32768) >>> 16;
		y = (y + 32768) >>> 16;
		if (flip) begin
			x = -x; y = -y;
		end
		v.x = clamp32(cx + x);
		v.y = clamp32(cy + y);
		v.lst = lst;
		return v;
	endfunction

	task automatic expect_vertex(vertex_t v);
		expected_vertices = {expected_vertices, v};
	endtask

	task automatic predict_polyline();
		longint cx, cy;
		int seg, span, q;
		logic [15:0] a0, a1;
		cx = center_x; cy = center_y;
		seg = segments;
		if (seg == 0) seg = 1;
		if (opcode == OP_CIRCLE) begin
			if (seg > MAXP) seg = MAXP;
			for (int i = 0; i < seg; i++)
				expect_vertex(point_on_circle(cx, cy, radius,
					16'((65536 * i) / seg), i == seg - 1));
			return;
		end
		if (opcode == OP_ARC_ANGLES) begin
			a0 = start_angle; a1 = end_angle;
		end else if (opcode == OP_ARC_POINTS) begin
			a0 = direction_angle(longint'(first_x) - cx, longint'(first_y) - cy);
			a1 = direction_angle(longint'(second_x) - cx, longint'(second_y) - cy);
		end else begin
			return;
		end
		if (seg > MAXP - 1) seg = MAXP - 1;
		span = int'(16'(a1 - a0));
		if (span >= 32768) span -= 65536;
		for (int i = 0; i <= seg; i++) begin
			q = (span * i) / seg;
			expect_vertex(point_on_circle(cx, cy, radius,
				16'(a0 + q[15:0]), i == seg));
		end
	endtask

	// drive one request, wait for acceptance, then idle for a random gap
	task automatic send_request(logic [1:0] op, logic [31:0] cx, logic [31:0] cy,
			logic [30:0] r, logic [15:0] sa, logic [15:0] ea, logic [31:0] fx,
			logic [31:0] fy, logic [31:0] sx, logic [31:0] sy, logic [6:0] seg);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
		@(negedge clk);
		opcode <= op; center_x <= cx; center_y <= cy; radius <= r;
		start_angle <= sa; end_angle <= ea; first_x <= fx; first_y <= fy;
		second_x <= sx; second_y <= sy; segments <= seg;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		predict_polyline();
		op_count[op]++;
		requests_sent++;
		@(negedge clk);
		req_valid <= 1'b0;
		repeat (gap) @(negedge clk);
	endtask

	always @(posedge clk) begin
		vertex_t e;
		if (arst_n && vtx_valid && !vtx_stall) begin
			vertices_seen++;
			if (expected_vertices.size() == 0) begin
				$error("unexpected vertex x=%0d y=%0d last=%0b", vertex_x, vertex_y, last);
				errors++;
			end else begin
				e = expected_vertices.pop_front();
				if (vertex_x !== e.x) begin
					$error("vertex_x expected %0d got %0d", e.x, vertex_x); errors++;
				end
				if (vertex_y !== e.y) begin
					$error("vertex_y expected %0d got %0d", e.y, vertex_y); errors++;
				end
				if (last !== e.lst) begin
					$error("last expected %0b got %0b", e.lst, last); errors++;
				end
			end
		end
	end

	// receiver back-pressure: alternating random-stall and open stretches, none while stall_enable is clear
	always @(negedge clk) begin
		if (!stall_enable) vtx_stall <= 1'b0;
		else if (($time / 20000) % 3 == 0) vtx_stall <= 1'b0;
		else vtx_stall <= ($urandom_range(0, 99) < 35);
	end

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
			2: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
			default: return 32'($signed($urandom_range(0, 20000)) - 10000) <<< 10;
		endcase
	endfunction

	function automatic logic [30:0] rand_radius();
		case ($urandom_range(0, 3))
			0: return 31'($urandom);
			1: return 31'h7FFFFFFF;
			default: return 31'($urandom_range(0, 500) << 16);
		endcase
	endfunction

	function automatic logic [6:0] rand_segments();
		// mostly small counts to keep the run short
		if ($urandom_range(0, 9) == 0) return 7'($urandom_range(60, 127));
		return 7'($urandom_range(0, 12));
	endfunction

	task automatic wait_drained();
		while (expected_vertices.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic test_field_extremes();
		send_request(OP_ARC_ANGLES, 0, 0, 31'h10000, 16'h0, 16'h4000, 0, 0, 0, 0, 7'd4);
		send_request(OP_ARC_ANGLES, 32'h7FFFFFFF, 32'h80000000, 31'h7FFFFFFF, 16'hFFFF,
			16'h0, 0, 0, 0, 0, 7'd3);
		send_request(OP_ARC_ANGLES, 32'h80000000, 32'h7FFFFFFF, 31'h7FFFFFFF, 16'h0,
			16'h8000, 0, 0, 0, 0, 7'd2);
		send_request(OP_ARC_ANGLES, 32'hFFFFFFFF, 32'hFFFFFFFF, 31'h0, 16'hAAAA, 16'h5555,
			0, 0, 0, 0, 7'd5);
		send_request(OP_ARC_ANGLES, 0, 0, 31'h55555555, 16'h8000, 16'h7FFF, 0, 0, 0, 0,
			7'd1);
	endtask

	task automatic test_every_opcode();
		send_request(OP_ARC_POINTS, 0, 0, 31'h50000, 0, 0, 32'h10000, 0, 0, 32'h10000,
			7'd4);
		send_request(OP_ARC_POINTS, 32'h100000, 32'hFFF00000, 31'h20000, 0, 0,
			32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 7'd6);
		send_request(OP_CIRCLE, 32'h30000, 32'hFFFD0000, 31'h80000, 0, 0, 0, 0, 0, 0,
			7'd8);
		send_request(OP_CIRCLE, 0, 0, 31'h7FFFFFFF, 0, 0, 0, 0, 0, 0, 7'd3);
	endtask

	task automatic test_special_cases();
		// unused opcode yields nothing
		send_request(OP_UNUSED, 32'h10000, 0, 31'h10000, 0, 16'h4000, 0, 0, 0, 0, 7'd4);
		// zero segments behaves as one
		send_request(OP_ARC_ANGLES, 0, 0, 31'h10000, 16'h1000, 16'h3000, 0, 0, 0, 0, 7'd0);
		send_request(OP_CIRCLE, 0, 0, 31'h10000, 0, 0, 0, 0, 0, 0, 7'd0);
		// segment saturation
		send_request(OP_ARC_ANGLES, 0, 0, 31'h100000, 16'h0, 16'h7000, 0, 0, 0, 0,
			7'd127);
		send_request(OP_ARC_ANGLES, 0, 0, 31'h100000, 16'h0, 16'h9000, 0, 0, 0, 0,
			7'd64);
		send_request(OP_CIRCLE, 0, 0, 31'h100000, 0, 0, 0, 0, 0, 0, 7'd64);
		send_request(OP_CIRCLE, 0, 0, 31'h100000, 0, 0, 0, 0, 0, 0, 7'd100);
		// ray points on the centre
		send_request(OP_ARC_POINTS, 32'h50000, 32'h60000, 31'h10000, 0, 0, 32'h50000,
			32'h60000, 32'h50000, 32'h60000, 7'd2);
		send_request(OP_ARC_POINTS, 32'h50000, 32'h60000, 31'h10000, 0, 0, 32'h50000,
			32'h60000, 32'h40000, 32'h60000, 7'd3);
		// vertex overflow on both sides
		send_request(OP_CIRCLE, 32'h7FFF0000, 32'h80010000, 31'h7FFFFFFF, 0, 0, 0, 0, 0,
			0, 7'd6);
		wait_drained();
	endtask

	task automatic test_drain_pause();
		send_request(OP_CIRCLE, 32'h10000, 32'h10000, 31'h30000, 0, 0, 0, 0, 0, 0, 7'd5);
		wait_drained();
		send_request(OP_ARC_ANGLES, 0, 0, 31'h30000, 16'hF000, 16'h1000, 0, 0, 0, 0, 7'd4);
	endtask

	task automatic test_random_requests(int count);
		logic [1:0] op;
		int burst;
		for (int n = 0; n < count; ) begin
			burst = $urandom_range(1, 20);
			stall_enable = ($urandom_range(0, 4) != 0);
			for (int b = 0; b < burst && n < count; b++, n++) begin
				op = ($urandom_range(0, 19) == 0) ? OP_UNUSED : 2'($urandom_range(0, 2));
				send_request(op, rand_coord(), rand_coord(), rand_radius(),
					16'($urandom), 16'($urandom), rand_coord(), rand_coord(),
					rand_coord(), rand_coord(), rand_segments());
			end
			repeat ($urandom_range(1, 40)) @(negedge clk);
		end
		stall_enable = 1'b1;
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);
		test_field_extremes();
		test_every_opcode();
		test_special_cases();
		test_drain_pause();
		test_random_requests(400);
		wait_drained();
		$display("Covered %0d requests (arc-angles %0d, arc-points %0d, circle %0d, unused %0d)",
			requests_sent, op_count[0], op_count[1], op_count[2], op_count[3]);
		$display("Checked %0d vertices under random sender gaps and receiver stalls",
			vertices_seen);
		if (errors == 0) $display("SCOREBOARD CLEAN");
		else $display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
